### rtl/core/dqs_pkg.sv
// ----------------------------------------------------------------------------
// dqs_pkg
// Shared types and codes for the deque with search.
// ----------------------------------------------------------------------------
package dqs_pkg;

	typedef enum logic [2:0] {
		CMD_PUSH_FRONT = 3'd0,
		CMD_PUSH_BACK  = 3'd1,
		CMD_POP_FRONT  = 3'd2,
		CMD_POP_BACK   = 3'd3,
		CMD_PEEK_FRONT = 3'd4,
		CMD_PEEK_BACK  = 3'd5,
		CMD_FIND       = 3'd6,
		CMD_REMOVE     = 3'd7
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_EMPTY     = 2'd2,
		ST_FULL      = 2'd3
	} status_t;

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_READ  = 5'b00010,
		S_SCAN  = 5'b00100,
		S_SHIFT = 5'b01000,
		S_DONE  = 5'b10000
	} state_t;

	localparam int VALUE_W = 32;
	localparam int IN_W    = 40;

endpackage

### rtl/core/deque_with_search.sv
// ----------------------------------------------------------------------------
// deque_with_search
// Bounded double-ended queue of data words with masked search and removal.
// ----------------------------------------------------------------------------
// One result word per input word; count is the fill level after the command.
// Entries live in a circular RAM with one write and one registered read port,
// and that single read port sets the timing: push writes its entry and goes
// to the result; pop and peek read the entry first (not when empty); find
// scans from the front until the match (to the end on a miss); and remove
// scans to the match, then moves each later entry one place toward the front.
// A finished result sits in the output register while the next word is
// accepted; a result still held there by the receiver adds its wait.
// ----------------------------------------------------------------------------
module deque_with_search #(
	parameter int DEPTH      = 64,
	parameter int DATA_WIDTH = 32,
	localparam int CW = $clog2(DEPTH + 1),
	localparam int OW = ((dqs_pkg::VALUE_W + 2 + CW + 7) / 8) * 8
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [31:0]              cfg_wdata,
	input  logic                     s_axis_tvalid,
	output logic                     s_axis_tready,
	input  logic [dqs_pkg::IN_W-1:0] s_axis_tdata,  // cmd[2:0], value[34:3]
	output logic                     m_axis_tvalid,
	input  logic                     m_axis_tready,
	output logic [OW-1:0]            m_axis_tdata   // value_out, status, count
);

	localparam int AW = $clog2(DEPTH);
	localparam int SW = (DATA_WIDTH < 32) ? DATA_WIDTH : 32;

	dqs_pkg::state_t  state_q;
	dqs_pkg::cmd_t    cmd_q;
	dqs_pkg::cmd_t    in_cmd;
	dqs_pkg::status_t res_st_q;
	dqs_pkg::status_t out_st_q;

	logic [AW-1:0] front_q;
	logic [AW-1:0] front_dec;
	logic [CW-1:0] count_q;
	logic [CW-1:0] ck_q;
	logic [SW-1:0] mask_q;
	logic [SW-1:0] key_q;
	logic [SW-1:0] in_val;
	logic [SW-1:0] res_val_q;
	logic [SW-1:0] out_val_q;
	logic [CW-1:0] out_cnt_q;

	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [SW-1:0] ram_wdata;
	logic          ram_re;
	logic [AW-1:0] ram_raddr;
	logic [SW-1:0] ram_rdata;

	logic s_fire;
	logic full;
	logic empty;
	logic match;
	logic scan_more;
	logic shift_more;
	logic shift_read;
	logic out_free;

	function automatic logic [AW-1:0] slot(input logic [AW-1:0] f, input logic [CW-1:0] k);
		logic [CW:0] s;
		s = (CW+1)'(f) + (CW+1)'(k);
		if (s >= (CW+1)'(DEPTH)) begin
			s = s - (CW+1)'(DEPTH);
		end
		return AW'(s);
	endfunction

	assign s_axis_tready = (state_q == dqs_pkg::S_IDLE);
	assign s_fire        = s_axis_tvalid & s_axis_tready;
	assign in_cmd        = dqs_pkg::cmd_t'(s_axis_tdata[2:0]);
	assign in_val        = SW'(s_axis_tdata[34:3]);
	assign full          = (count_q == CW'(DEPTH));
	assign empty         = (count_q == '0);
	assign front_dec     = (front_q == '0) ? AW'(DEPTH - 1) : front_q - AW'(1);
	assign match         = ((ram_rdata ^ key_q) & mask_q) == '0;
	assign scan_more     = ((CW+1)'(ck_q) + (CW+1)'(1)) < (CW+1)'(count_q);
	assign shift_more    = scan_more;
	assign shift_read    = ((CW+1)'(ck_q) + (CW+1)'(2)) < (CW+1)'(count_q);
	assign out_free      = !m_axis_tvalid || m_axis_tready;

	// RAM port control
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = front_q;
		ram_wdata = in_val;
		ram_re    = 1'b0;
		ram_raddr = front_q;
		unique case (state_q)
			dqs_pkg::S_IDLE: begin
				if (s_fire) begin
					unique case (in_cmd)
						dqs_pkg::CMD_PUSH_FRONT: begin
							ram_we    = !full;
							ram_waddr = front_dec;
						end
						dqs_pkg::CMD_PUSH_BACK: begin
							ram_we    = !full;
							ram_waddr = slot(front_q, count_q);
						end
						dqs_pkg::CMD_POP_BACK, dqs_pkg::CMD_PEEK_BACK: begin
							ram_re    = !empty;
							ram_raddr = slot(front_q, count_q - CW'(1));
						end
						default: begin
							ram_re = !empty;
						end
					endcase
				end
			end
			dqs_pkg::S_SCAN: begin
				ram_re    = scan_more;
				ram_raddr = slot(front_q, ck_q + CW'(1));
			end
			dqs_pkg::S_SHIFT: begin
				ram_we    = shift_more;
				ram_waddr = slot(front_q, ck_q);
				ram_wdata = ram_rdata;
				ram_re    = shift_read;
				ram_raddr = slot(front_q, CW'((CW+1)'(ck_q) + (CW+1)'(2)));
			end
			default: begin
			end
		endcase
	end

	dqs_ram #(
		.WIDTH(SW),
		.DEPTH(DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= dqs_pkg::S_IDLE;
			front_q       <= '0;
			count_q       <= '0;
			ck_q          <= '0;
			mask_q        <= '1;
			m_axis_tvalid <= 1'b0;
		end else begin
			if (cfg_we) begin
				mask_q <= SW'(cfg_wdata);
			end
			unique case (state_q)
				dqs_pkg::S_IDLE: begin
					if (s_fire) begin
						ck_q <= '0;
						unique case (in_cmd)
							dqs_pkg::CMD_PUSH_FRONT: begin
								if (!full) begin
									front_q <= front_dec;
									count_q <= count_q + CW'(1);
								end
								state_q <= dqs_pkg::S_DONE;
							end
							dqs_pkg::CMD_PUSH_BACK: begin
								if (!full) begin
									count_q <= count_q + CW'(1);
								end
								state_q <= dqs_pkg::S_DONE;
							end
							dqs_pkg::CMD_POP_FRONT: begin
								if (!empty) begin
									front_q <= slot(front_q, CW'(1));
									count_q <= count_q - CW'(1);
								end
								state_q <= empty ? dqs_pkg::S_DONE : dqs_pkg::S_READ;
							end
							dqs_pkg::CMD_POP_BACK: begin
								if (!empty) begin
									count_q <= count_q - CW'(1);
								end
								state_q <= empty ? dqs_pkg::S_DONE : dqs_pkg::S_READ;
							end
							dqs_pkg::CMD_PEEK_FRONT, dqs_pkg::CMD_PEEK_BACK: begin
								state_q <= empty ? dqs_pkg::S_DONE : dqs_pkg::S_READ;
							end
							default: begin
								state_q <= empty ? dqs_pkg::S_DONE : dqs_pkg::S_SCAN;
							end
						endcase
					end
				end
				dqs_pkg::S_READ: begin
					state_q <= dqs_pkg::S_DONE;
				end
				dqs_pkg::S_SCAN: begin
					priority if (match) begin
						state_q <= (cmd_q == dqs_pkg::CMD_REMOVE) ? dqs_pkg::S_SHIFT
							: dqs_pkg::S_DONE;
					end else if (!scan_more) begin
						state_q <= dqs_pkg::S_DONE;
					end else begin
						ck_q <= ck_q + CW'(1);
					end
				end
				dqs_pkg::S_SHIFT: begin
					if (shift_more) begin
						ck_q <= ck_q + CW'(1);
					end else begin
						count_q <= count_q - CW'(1);
						state_q <= dqs_pkg::S_DONE;
					end
				end
				dqs_pkg::S_DONE: begin
					if (out_free) begin
						state_q <= dqs_pkg::S_IDLE;
					end
				end
				default: begin
					state_q <= dqs_pkg::S_IDLE;
				end
			endcase
			priority if (state_q == dqs_pkg::S_DONE && out_free) begin
				m_axis_tvalid <= 1'b1;
			end else if (m_axis_tready) begin
				m_axis_tvalid <= 1'b0;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (s_fire) begin
			cmd_q     <= in_cmd;
			key_q     <= in_val;
			res_val_q <= '0;
			unique case (in_cmd)
				dqs_pkg::CMD_PUSH_FRONT, dqs_pkg::CMD_PUSH_BACK: begin
					res_st_q <= full ? dqs_pkg::ST_FULL : dqs_pkg::ST_OK;
				end
				dqs_pkg::CMD_FIND, dqs_pkg::CMD_REMOVE: begin
					res_st_q <= empty ? dqs_pkg::ST_NOT_FOUND : dqs_pkg::ST_OK;
				end
				default: begin
					res_st_q <= empty ? dqs_pkg::ST_EMPTY : dqs_pkg::ST_OK;
				end
			endcase
		end
		if (state_q == dqs_pkg::S_READ) begin
			res_val_q <= ram_rdata;
		end
		if (state_q == dqs_pkg::S_SCAN) begin
			priority if (match) begin
				res_val_q <= ram_rdata;
			end else if (!scan_more) begin
				res_st_q <= dqs_pkg::ST_NOT_FOUND;
			end
		end
		if (state_q == dqs_pkg::S_DONE && out_free) begin
			out_val_q <= res_val_q;
			out_st_q  <= res_st_q;
			out_cnt_q <= count_q;
		end
	end

	assign m_axis_tdata = OW'({out_cnt_q, out_st_q, dqs_pkg::VALUE_W'(out_val_q)});

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("fill level above depth");

	a_shift_ports: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == dqs_pkg::S_SHIFT && ram_we && ram_re) |-> ram_waddr != ram_raddr)
		else $error("shift reads the entry it writes");

	a_push_count: assert property (@(posedge clk) disable iff (!arst_n)
		(s_fire && !full && (in_cmd == dqs_pkg::CMD_PUSH_FRONT ||
			in_cmd == dqs_pkg::CMD_PUSH_BACK)) |=> count_q == $past(count_q) + CW'(1))
		else $error("push did not grow the deque");

	a_scan_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == dqs_pkg::S_SCAN |-> ck_q < count_q)
		else $error("scan beyond held entries");

endmodule

### rtl/core/dqs_ram.sv
// ----------------------------------------------------------------------------
// dqs_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module dqs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deque_with_search testbench
// Drives push, pop, peek, find and remove words through the command stream.
// A mirror deque inside the testbench predicts each reply word, and every
// reply is checked field by field. The run steps through several key masks
// and several patterns of sender and receiver stalls.
// ----------------------------------------------------------------------------
module testbench;

	localparam int DEPTH     = 64;
	localparam int MAX_CYCLES = 1000000;

	typedef struct packed {
		logic [6:0]       count;
		dqs_pkg::status_t status;
		logic [31:0]      value_out;
	} reply_t;

	class deque_mirror;
		logic [31:0] slots[DEPTH];
		int unsigned front;
		int unsigned fill;
		logic [31:0] key_mask = 32'hFFFF_FFFF;
		reply_t      replies_due[$];
		int          errors;

		function void note_command(dqs_pkg::cmd_t cmd, logic [31:0] val);
			reply_t r;
			int unsigned k;
			r.value_out = '0;
			r.status    = dqs_pkg::ST_OK;
			case (cmd)
				dqs_pkg::CMD_PUSH_FRONT, dqs_pkg::CMD_PUSH_BACK: begin
					if (fill == DEPTH) begin
						r.status = dqs_pkg::ST_FULL;
					end else if (cmd == dqs_pkg::CMD_PUSH_FRONT) begin
						front = (front + DEPTH - 1) % DEPTH;
						slots[front] = val;
						fill++;
					end else begin
						slots[(front + fill) % DEPTH] = val;
						fill++;
					end
				end
				dqs_pkg::CMD_POP_FRONT, dqs_pkg::CMD_PEEK_FRONT: begin
					if (fill == 0) begin
						r.status = dqs_pkg::ST_EMPTY;
					end else begin
						r.value_out = slots[front];
						if (cmd == dqs_pkg::CMD_POP_FRONT) begin
							front = (front + 1) % DEPTH;
							fill--;
						end
					end
				end
				dqs_pkg::CMD_POP_BACK, dqs_pkg::CMD_PEEK_BACK: begin
					if (fill == 0) begin
						r.status = dqs_pkg::ST_EMPTY;
					end else begin
						r.value_out = slots[(front + fill - 1) % DEPTH];
						if (cmd == dqs_pkg::CMD_POP_BACK)
							fill--;
					end
				end
				default: begin
					k = 0;
					while (k < fill && ((slots[(front + k) % DEPTH] ^ val) & key_mask) != 0)
						k++;
					if (k == fill) begin
						r.status = dqs_pkg::ST_NOT_FOUND;
					end else begin
						r.value_out = slots[(front + k) % DEPTH];
						if (cmd == dqs_pkg::CMD_REMOVE) begin
							while (k + 1 < fill) begin
								slots[(front + k) % DEPTH] = slots[(front + k + 1) % DEPTH];
								k++;
							end
							fill--;
						end
					end
				end
			endcase
			r.count = fill[6:0];
			replies_due.push_back(r);
		endfunction

		function void check_reply(logic [47:0] word);
			reply_t got;
			reply_t want;
			got = word[40:0];
			if (replies_due.size() == 0) begin
				$error("reply word %h with nothing expected", word);
				errors++;
			end else begin
				want = replies_due.pop_front();
				if (got.value_out !== want.value_out) begin
					$error("value_out: expected %h, got %h", want.value_out, got.value_out);
					errors++;
				end
				if (got.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, got.status);
					errors++;
				end
				if (got.count !== want.count) begin
					$error("count: expected %0d, got %0d", want.count, got.count);
					errors++;
				end
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [31:0] cfg_wdata = '0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [39:0] s_axis_tdata = '0;    // cmd[2:0], value[34:3]
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [47:0] m_axis_tdata;         // value_out[31:0], status[33:32], count[40:34]

	deque_mirror mirror = new;
	int          src_idle_pct;
	int          sink_idle_pct;
	int          hold_left;
	int          cycle_count;

	deque_with_search #(.DEPTH(DEPTH), .DATA_WIDTH(32)) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= MAX_CYCLES) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// receiver: random stalls plus long hold-offs on request
	initial forever begin
		@(posedge clk);
		if (m_axis_tvalid && m_axis_tready)
			mirror.check_reply(m_axis_tdata);
		if (hold_left > 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
		end
	end

	task automatic send_word(dqs_pkg::cmd_t cmd, logic [31:0] val);
		while ($urandom_range(99) < src_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {5'b0, val, cmd};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		mirror.note_command(cmd, val);
	endtask

	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		while (mirror.replies_due.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_key_mask(logic [31:0] mask);
		wait_drained();
		cfg_we    <= 1'b1;
		cfg_wdata <= mask;
		@(posedge clk);
		cfg_we <= 1'b0;
		mirror.key_mask = mask;
	endtask

	task automatic random_words(int n, int push_pct);
		dqs_pkg::cmd_t cmd;
		logic [31:0]   val;
		int unsigned   pos;
		repeat (n) begin
			if ($urandom_range(99) < push_pct)
				cmd = $urandom_range(1) ? dqs_pkg::CMD_PUSH_FRONT
					: dqs_pkg::CMD_PUSH_BACK;
			else
				cmd = dqs_pkg::cmd_t'($urandom_range(7, 2));
			if ((cmd == dqs_pkg::CMD_FIND || cmd == dqs_pkg::CMD_REMOVE)
					&& mirror.fill != 0 && $urandom_range(99) < 65) begin
				// key built from a held entry, bits outside the mask scrambled
				pos = $urandom_range(mirror.fill - 1);
				val = mirror.slots[(mirror.front + pos) % DEPTH]
					^ ($urandom & ~mirror.key_mask);
			end else begin
				case ($urandom_range(3))
					0, 1: val = $urandom;
					2: val = ($urandom & 32'hFFFF_FF00) | $urandom_range(3);
					default: val = $urandom_range(3) * 32'h4001_0003;
				endcase
			end
			send_word(cmd, val);
		end
	endtask

	initial begin
		src_idle_pct  = 9;
		sink_idle_pct = 80;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty deque, reset key mask
		send_word(dqs_pkg::CMD_POP_FRONT, 32'h0);
		send_word(dqs_pkg::CMD_POP_BACK, 32'hFFFF_FFFF);
		send_word(dqs_pkg::CMD_PEEK_FRONT, 32'h0);
		send_word(dqs_pkg::CMD_PEEK_BACK, 32'h0);
		send_word(dqs_pkg::CMD_FIND, 32'h0);
		send_word(dqs_pkg::CMD_REMOVE, 32'hFFFF_FFFF);
		send_word(dqs_pkg::CMD_PUSH_BACK, 32'h0000_0000);
		send_word(dqs_pkg::CMD_PUSH_BACK, 32'hFFFF_FFFF);
		send_word(dqs_pkg::CMD_PUSH_FRONT, 32'h8000_0001);
		send_word(dqs_pkg::CMD_PUSH_FRONT, 32'h7FFF_FFFE);
		send_word(dqs_pkg::CMD_PEEK_FRONT, 32'h0);
		send_word(dqs_pkg::CMD_PEEK_BACK, 32'h0);
		send_word(dqs_pkg::CMD_FIND, 32'hFFFF_FFFF);
		send_word(dqs_pkg::CMD_FIND, 32'h1234_5678);
		send_word(dqs_pkg::CMD_REMOVE, 32'h0000_0000);
		send_word(dqs_pkg::CMD_REMOVE, 32'h1234_5678);
		send_word(dqs_pkg::CMD_POP_BACK, 32'h0);
		send_word(dqs_pkg::CMD_POP_FRONT, 32'h0);
		send_word(dqs_pkg::CMD_REMOVE, 32'h8000_0001);
		send_word(dqs_pkg::CMD_PEEK_BACK, 32'h0);

		write_key_mask(32'hFFFF_FFFF);
		random_words(150, 55);
		write_key_mask(32'h0000_00FF);
		random_words(150, 80);

		src_idle_pct  = 80;
		sink_idle_pct = 9;
		write_key_mask(32'h0000_0000);
		random_words(150, 25);
		write_key_mask(32'hFFFF_0000);
		random_words(150, 55);

		src_idle_pct  = 0;
		sink_idle_pct = 0;
		write_key_mask($urandom);
		random_words(100, 80);
		wait_drained();
		random_words(100, 80);
		write_key_mask(32'h0000_FFFF);
		hold_left = 400;
		random_words(200, 50);
		hold_left = 300;
		random_words(150, 20);

		wait_drained();
		repeat (10) @(posedge clk);
		if (mirror.errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

### sim.f
rtl/core/dqs_pkg.sv
rtl/core/dqs_ram.sv
rtl/core/deque_with_search.sv
sim/testbench.sv
